// ===== rtl/core/acpu_pkg.sv =====
// Shared types, opcode constants and the microcode table of the accumulator CPU.
package acpu_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int DATA_W          = 8;
  localparam int MEM_DEPTH       = 256;
  localparam int ADDR_W          = $clog2(MEM_DEPTH);

  // Lower bounds of the opcode ranges.
  localparam logic [DATA_W-1:0] OP_STA = 8'h10;
  localparam logic [DATA_W-1:0] OP_LDA = 8'h20;
  localparam logic [DATA_W-1:0] OP_ADD = 8'h30;
  localparam logic [DATA_W-1:0] OP_OR  = 8'h40;
  localparam logic [DATA_W-1:0] OP_AND = 8'h50;
  localparam logic [DATA_W-1:0] OP_NOT = 8'h60;
  localparam logic [DATA_W-1:0] OP_JMP = 8'h80;
  localparam logic [DATA_W-1:0] OP_JN  = 8'h90;
  localparam logic [DATA_W-1:0] OP_JZ  = 8'hA0;
  localparam logic [DATA_W-1:0] OP_HLT = 8'hF0;

  localparam logic [ADDR_W-1:0] PC_LAST = 8'hFF;

  localparam logic [1:0] ST_CONTINUE = 2'd0;
  localparam logic [1:0] ST_HALT     = 2'd1;
  localparam logic [1:0] ST_MEMDONE  = 2'd2;

  localparam logic [1:0] CMD_EXEC  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] mem_address;
    logic [DATA_W-1:0] mem_write_data;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [DATA_W-1:0] read_data;
    logic [DATA_W-1:0] acc_value;
    logic [ADDR_W-1:0] pc_value;
    logic              negative_flag;
    logic              zero_flag;
    logic [31:0]       instr_count;
    logic [31:0]       access_count;
  } rsp_t;

  typedef enum logic [2:0] {
    CLS_NOP, CLS_DATA, CLS_NOT, CLS_JUMP, CLS_HLT
  } op_class_t;

  typedef enum logic [3:0] {
    U_IDLE, U_FETCH, U_OPND, U_DISP, U_NOP, U_DATA, U_DATA2, U_NOT,
    U_JUMP, U_HLT, U_FIN, U_WRITE, U_READ, U_READ2, U_NONE
  } upc_t;

  typedef enum logic [1:0] {ADDR_PC, ADDR_PC1, ADDR_ARG, ADDR_CMD} addr_sel_t;
  typedef enum logic [1:0] {PC_KEEP, PC_INC1, PC_INC2, PC_BRANCH} pc_op_t;
  typedef enum logic [1:0] {ACC_KEEP, ACC_ALU, ACC_NOT} acc_op_t;
  typedef enum logic [1:0] {EMIT_NONE, EMIT_EXEC, EMIT_MEM, EMIT_READ} emit_t;
  typedef enum logic [2:0] {NXT_WAIT, NXT_SEQ, NXT_GOTO, NXT_DISPATCH, NXT_IDLE} nxt_t;

  typedef struct packed {
    addr_sel_t  addr_sel;
    logic       we_cmd;
    logic       we_acc;
    logic       ld_ir;
    logic       ld_arg;
    pc_op_t     pc_op;
    acc_op_t    acc_op;
    logic [1:0] cnt_add;
    logic       fin;
    emit_t      emit;
    nxt_t       nxt;
    upc_t       target;
  } ctrl_t;

  typedef struct packed {
    logic       in_fire;
    logic [1:0] command;
    op_class_t  cls;
    logic       out_blocked;
  } seq_stat_t;

  typedef struct packed {
    ctrl_t ctrl;
    logic  step_en;
    logic  idle;
  } seq_out_t;

  function automatic op_class_t op_class(input logic [DATA_W-1:0] op);
    op_class_t c;
    if (op < OP_STA)      c = CLS_NOP;
    else if (op < OP_NOT) c = CLS_DATA;
    else if (op < OP_JMP) c = CLS_NOT;
    else if (op < OP_HLT) c = CLS_JUMP;
    else                  c = CLS_HLT;
    return c;
  endfunction

  // Microcode ROM: one control word per step.
  function automatic ctrl_t ucode(input upc_t u);
    ctrl_t c;
    c = '0;
    unique case (u)
      U_IDLE:  c.nxt = NXT_WAIT;
      U_FETCH: begin
        c.addr_sel = ADDR_PC;
        c.nxt      = NXT_SEQ;
      end
      U_OPND: begin
        c.addr_sel = ADDR_PC1;
        c.ld_ir    = 1'b1;
        c.nxt      = NXT_SEQ;
      end
      U_DISP: begin
        c.ld_arg = 1'b1;
        c.nxt    = NXT_DISPATCH;
      end
      U_NOP: begin
        c.pc_op   = PC_INC1;
        c.cnt_add = 2'd1;
        c.nxt     = NXT_GOTO;
        c.target  = U_FIN;
      end
      U_DATA: begin
        c.addr_sel = ADDR_ARG;
        c.we_acc   = 1'b1;
        c.nxt      = NXT_SEQ;
      end
      U_DATA2: begin
        c.acc_op  = ACC_ALU;
        c.pc_op   = PC_INC2;
        c.cnt_add = 2'd3;
        c.nxt     = NXT_GOTO;
        c.target  = U_FIN;
      end
      U_NOT: begin
        c.acc_op  = ACC_NOT;
        c.pc_op   = PC_INC1;
        c.cnt_add = 2'd1;
        c.nxt     = NXT_GOTO;
        c.target  = U_FIN;
      end
      U_JUMP: begin
        c.pc_op   = PC_BRANCH;
        c.cnt_add = 2'd2;
        c.nxt     = NXT_GOTO;
        c.target  = U_FIN;
      end
      U_HLT: begin
        c.pc_op   = PC_INC1;
        c.cnt_add = 2'd1;
        c.nxt     = NXT_GOTO;
        c.target  = U_FIN;
      end
      U_FIN: begin
        c.fin  = 1'b1;
        c.emit = EMIT_EXEC;
        c.nxt  = NXT_IDLE;
      end
      U_WRITE: begin
        c.addr_sel = ADDR_CMD;
        c.we_cmd   = 1'b1;
        c.emit     = EMIT_MEM;
        c.nxt      = NXT_IDLE;
      end
      U_READ: begin
        c.addr_sel = ADDR_CMD;
        c.nxt      = NXT_SEQ;
      end
      U_READ2: begin
        c.addr_sel = ADDR_CMD;
        c.emit     = EMIT_READ;
        c.nxt      = NXT_IDLE;
      end
      U_NONE: begin
        c.emit = EMIT_MEM;
        c.nxt  = NXT_IDLE;
      end
      default: c.nxt = NXT_IDLE;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/acpu_ram.sv =====
// Generic single-port RAM with a registered read.
module acpu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/acpu_seq.sv =====
// Microcode sequencer: step counter, control word lookup and branching.
module acpu_seq (
  input  logic                clk,
  input  logic                rst,
  input  acpu_pkg::seq_stat_t stat,
  output acpu_pkg::seq_out_t  so
);
  import acpu_pkg::*;

  upc_t  upc;
  upc_t  upc_next;
  ctrl_t ctrl;
  logic  stall;

  function automatic upc_t entry(input logic [1:0] command);
    upc_t u;
    unique case (command)
      CMD_EXEC:  u = U_FETCH;
      CMD_WRITE: u = U_WRITE;
      CMD_READ:  u = U_READ;
      default:   u = U_NONE;
    endcase
    return u;
  endfunction

  function automatic upc_t dispatch(input op_class_t cls);
    upc_t u;
    unique case (cls)
      CLS_NOP:  u = U_NOP;
      CLS_DATA: u = U_DATA;
      CLS_NOT:  u = U_NOT;
      CLS_JUMP: u = U_JUMP;
      default:  u = U_HLT;
    endcase
    return u;
  endfunction

  // Output logic: the control word of the current step.
  always_comb begin
    ctrl       = ucode(upc);
    stall      = (ctrl.emit != EMIT_NONE) && stat.out_blocked;
    so.ctrl    = ctrl;
    so.step_en = !stall;
    so.idle    = (upc == U_IDLE);
  end

  // Next step logic.
  always_comb begin
    upc_next = upc;
    if (!stall) begin
      unique case (ctrl.nxt)
        NXT_WAIT:     upc_next = stat.in_fire ? entry(stat.command) : U_IDLE;
        NXT_SEQ:      upc_next = upc_t'(4'(upc) + 4'd1);
        NXT_GOTO:     upc_next = ctrl.target;
        NXT_DISPATCH: upc_next = dispatch(stat.cls);
        default:      upc_next = U_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= U_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

// ===== rtl/core/accumulator_cpu_step.sv =====
// Top level of the 8-bit accumulator CPU step engine with its 256-byte memory.
// Execute steps: fetch, operand, dispatch, class step (two for STA, LDA, ADD, OR, AND),
// finish; a write takes one step, a read two. One item at a time; the next can be
// accepted in the cycle after the result is registered. One microcode step per cycle
// unless a result waits on rsp_ready; opcode, operand and data byte are three dependent
// single-port RAM reads. Reset clears registers, counters and memory valid bits.
module accumulator_cpu_step #(
  parameter int COUNT_WIDTH = acpu_pkg::COUNT_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  acpu_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output acpu_pkg::rsp_t rsp
);
  import acpu_pkg::*;

  // Architectural state.
  logic [DATA_W-1:0]      acc;
  logic [ADDR_W-1:0]      pc;
  logic                   neg;
  logic                   zero;
  logic [COUNT_WIDTH-1:0] instr_cnt;
  logic [COUNT_WIDTH-1:0] access_cnt;

  // Instruction and command holding registers.
  cmd_t              req;
  logic [DATA_W-1:0] ir;
  logic [ADDR_W-1:0] arg;

  // The memory resets to all zero: every byte carries a valid bit, and a byte
  // that has never been written reads as zero.
  logic [MEM_DEPTH-1:0] mem_valid;
  logic                 rd_valid;
  logic [ADDR_W-1:0]    ram_addr;
  logic                 ram_we;
  logic [DATA_W-1:0]    ram_wdata;
  logic [DATA_W-1:0]    ram_rdata;
  logic [DATA_W-1:0]    mem_rdata;

  seq_stat_t stat;
  seq_out_t  so;
  ctrl_t     ctrl;
  op_class_t cls;
  logic      cmd_fire;
  logic      take;
  logic      rsp_load;
  rsp_t      rsp_next;

  logic [DATA_W-1:0] acc_next;
  logic [ADDR_W-1:0] pc_next;

  assign ctrl      = so.ctrl;
  assign cls       = op_class(ir);
  assign cmd_ready = so.idle;
  assign cmd_fire  = cmd_valid && cmd_ready;

  always_comb begin
    stat.in_fire     = cmd_fire;
    stat.command     = cmd.command;
    stat.cls         = cls;
    stat.out_blocked = rsp_valid && !rsp_ready;
  end

  acpu_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .so   (so)
  );

  // The single memory port serves the opcode, the operand, the data byte and
  // the host write and read commands, one access per step.
  always_comb begin
    unique case (ctrl.addr_sel)
      ADDR_PC:  ram_addr = pc;
      ADDR_PC1: ram_addr = pc + 8'd1;
      ADDR_ARG: ram_addr = arg;
      default:  ram_addr = req.mem_address;
    endcase
    // STA is the only data instruction that writes memory.
    ram_we    = so.step_en && (ctrl.we_cmd || (ctrl.we_acc && (ir < OP_LDA)));
    ram_wdata = ctrl.we_cmd ? req.mem_write_data : acc;
  end

  acpu_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign mem_rdata = rd_valid ? ram_rdata : '0;

  // Accumulator update. Within the data class the opcode range picks the ALU
  // function; STA leaves the accumulator alone.
  always_comb begin
    case (ctrl.acc_op)
      ACC_NOT: acc_next = ~acc;
      ACC_ALU: begin
        if (ir < OP_LDA)      acc_next = acc;
        else if (ir < OP_ADD) acc_next = mem_rdata;
        else if (ir < OP_OR)  acc_next = acc + mem_rdata;
        else if (ir < OP_AND) acc_next = acc | mem_rdata;
        else                  acc_next = acc & mem_rdata;
      end
      default: acc_next = acc;
    endcase
  end

  // Program counter update. JMP always branches, JN on a negative accumulator
  // and JZ on a zero accumulator; a branch not taken skips the operand.
  always_comb begin
    if (ir < OP_JN)      take = 1'b1;
    else if (ir < OP_JZ) take = acc[DATA_W-1];
    else                 take = (acc == '0);
    case (ctrl.pc_op)
      PC_INC1:   pc_next = pc + 8'd1;
      PC_INC2:   pc_next = pc + 8'd2;
      PC_BRANCH: pc_next = take ? arg : pc + 8'd2;
      default:   pc_next = pc;
    endcase
  end

  // Result assembly. On the final step of an execute item the accumulator and
  // PC already hold their new values, while the flags and the instruction
  // counter are updated at the same edge that loads the result.
  always_comb begin
    rsp_load                = so.step_en && (ctrl.emit != EMIT_NONE);
    rsp_next.acc_value      = acc;
    rsp_next.pc_value       = pc;
    rsp_next.access_count   = 32'(access_cnt);
    rsp_next.read_data      = '0;
    if (ctrl.emit == EMIT_EXEC) begin
      rsp_next.status        = ((cls == CLS_HLT) || (pc == PC_LAST)) ? ST_HALT : ST_CONTINUE;
      rsp_next.negative_flag = acc[DATA_W-1];
      rsp_next.zero_flag     = (acc == '0);
      rsp_next.instr_count   = 32'(instr_cnt + COUNT_WIDTH'(1));
    end else begin
      rsp_next.status        = ST_MEMDONE;
      rsp_next.negative_flag = neg;
      rsp_next.zero_flag     = zero;
      rsp_next.instr_count   = 32'(instr_cnt);
      if (ctrl.emit == EMIT_READ) begin
        rsp_next.read_data = mem_rdata;
      end
    end
  end

  // Control state and architectural registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      pc         <= '0;
      neg        <= 1'b0;
      zero       <= 1'b0;
      instr_cnt  <= '0;
      access_cnt <= '0;
      mem_valid  <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (so.step_en) begin
        acc        <= acc_next;
        pc         <= pc_next;
        access_cnt <= access_cnt + COUNT_WIDTH'(ctrl.cnt_add);
        if (ctrl.fin) begin
          neg       <= acc[DATA_W-1];
          zero      <= (acc == '0);
          instr_cnt <= instr_cnt + COUNT_WIDTH'(1);
        end
      end
      if (ram_we) begin
        mem_valid[ram_addr] <= 1'b1;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_valid <= mem_valid[ram_addr];
    if (cmd_fire) begin
      req <= cmd;
    end
    if (so.step_en && ctrl.ld_ir) begin
      ir <= mem_rdata;
    end
    if (so.step_en && ctrl.ld_arg) begin
      arg <= mem_rdata;
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  // Only one item is in flight: acceptance closes the input until the result
  // has been registered.
  assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("item accepted while another is in flight");

  // A new result never overwrites one that is still waiting.
  assert property (@(posedge clk) disable iff (rst)
    rsp_load |-> (!rsp_valid || rsp_ready))
    else $error("result register overwritten");

  // Results of execute items carry flags that match their accumulator.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status != ST_MEMDONE)) |->
      ((rsp.zero_flag == (rsp.acc_value == '0)) &&
       (rsp.negative_flag == rsp.acc_value[DATA_W-1])))
    else $error("flags disagree with accumulator");

  // The access counter moves only on a microcode step that counts accesses.
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (access_cnt != $past(access_cnt))) |->
      $past(so.step_en && (ctrl.cnt_add != 2'd0)))
    else $error("access counter changed outside an execute step");

endmodule
